// File: sv/wsdm_pkg.sv
// Shared types, constants and tables of the wind speed and direction monitor.
`timescale 1ns / 1ps
`default_nettype none

package wsdm_pkg;

    localparam int ADC_WIDTH    = 12;
    localparam int SECTORS      = 16;
    localparam int SECTOR_W     = 4;
    localparam int CNT_W        = 16;
    localparam int SUM_W        = 23;
    localparam int SAMPLE_W     = 8;
    localparam int SCALE_W      = 8;
    localparam int SPEED_W      = 24;
    localparam int ANGLE_W      = 16;
    localparam int TRIG_W       = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int CORDIC_SHIFT = 8;
    localparam int CORDIC_W     = 33;
    localparam int CFG_IDX_W    = 2;

    localparam logic [SAMPLE_W-1:0] MAX_SAMPLES = 8'd255;
    localparam logic [CNT_W-1:0]    CNT_MAX     = 16'hFFFF;
    localparam logic [ANGLE_W-1:0]  HALF_TURN   = 16'h8000;

    // Event kinds on the input channel
    typedef enum logic [1:0] {
        MODE_PULSE  = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_AVG_SCALE  = 2'd1,
        CFG_PEAK_SCALE = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MATCH = 2'd1,
        ST_MEAN  = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    // Request to the angle unit
    typedef struct packed {
        logic                    start;
        logic [SUM_W-1:0]        sum_cos;
        logic [SUM_W-1:0]        sum_sin;
    } cordic_req_t;

    // Answer from the angle unit
    typedef struct packed {
        logic                    done;
        logic [ANGLE_W-1:0]      angle;
    } cordic_rsp_t;

    // Vane calibration voltages in ADC counts, one per sector
    function automatic logic [ADC_WIDTH-1:0] vane_adc(input logic [SECTOR_W-1:0] idx);
        logic [ADC_WIDTH-1:0] v;
        case (idx)
            4'd0:    v = 12'd510;
            4'd1:    v = 12'd1707;
            4'd2:    v = 12'd1491;
            4'd3:    v = 12'd3467;
            4'd4:    v = 12'd3376;
            4'd5:    v = 12'd3572;
            4'd6:    v = 12'd2789;
            4'd7:    v = 12'd3149;
            4'd8:    v = 12'd2237;
            4'd9:    v = 12'd2454;
            4'd10:   v = 12'd929;
            4'd11:   v = 12'd1022;
            4'd12:   v = 12'd153;
            4'd13:   v = 12'd410;
            4'd14:   v = 12'd276;
            default: v = 12'd724;
        endcase
        return v;
    endfunction

    // Sector cosine in Q1.14
    function automatic logic signed [TRIG_W-1:0] cos_q14(input logic [SECTOR_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        case (idx)
            4'd0:    v = 16'sd16384;
            4'd1:    v = 16'sd15137;
            4'd2:    v = 16'sd11585;
            4'd3:    v = 16'sd6270;
            4'd4:    v = 16'sd0;
            4'd5:    v = -16'sd6270;
            4'd6:    v = -16'sd11585;
            4'd7:    v = -16'sd15137;
            4'd8:    v = -16'sd16384;
            4'd9:    v = -16'sd15137;
            4'd10:   v = -16'sd11585;
            4'd11:   v = -16'sd6270;
            4'd12:   v = 16'sd0;
            4'd13:   v = 16'sd6270;
            4'd14:   v = 16'sd11585;
            default: v = 16'sd15137;
        endcase
        return v;
    endfunction

    // Sector sine in Q1.14: a quarter turn behind the cosine
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [SECTOR_W-1:0] idx);
        return cos_q14(idx - 4'd4);
    endfunction

    // atan(2^-i) in units of 65536 per circle
    function automatic logic [ANGLE_W-1:0] atan_units(input logic [STEP_W-1:0] step);
        logic [ANGLE_W-1:0] v;
        case (step)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/wind_speed_direction_monitor.sv
// Top level of the wind speed and direction monitor: sequencer, counters and result word.
//
// Input channel (in_valid, in_stall, mode, adc_sample) takes one event word:
// an anemometer pulse, a vane sample tick or a report tick. in_stall is high
// while an event is being worked on. Every event gives exactly one result word
// on the output channel (out_valid, out_stall and the result fields); fields
// that the event kind does not produce are zero.
// Work per event: a pulse or an unused kind goes straight to the result load; a
// sample tick first runs the calibration search, which tests one table entry a
// cycle until the first match or the last entry; a report tick first starts the
// iterative CORDIC unit and waits for its load and 16 steps, which are skipped
// when both sums are zero. The word appears as in_stall falls.
// The result sits in an output register, so a new event is accepted while a
// finished result waits; if out_stall is held, the following result waits in
// the sequencer and in_stall stays high until the output register frees.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while the block is idle.
// Reset clears the counters, sums, peak and output valid flag and loads the
// register defaults: tolerance 62, average scale 24, peak scale 80.
`timescale 1ns / 1ps
`default_nettype none

module wind_speed_direction_monitor
    import wsdm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // event channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              mode,
    input  wire logic [ADC_WIDTH-1:0]    adc_sample,
    // result channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         dir_valid,
    output logic [SECTOR_W-1:0]          dir_sector,
    output logic                         report_valid,
    output logic [SPEED_W-1:0]           avg_speed,
    output logic [SPEED_W-1:0]           peak_speed,
    output logic [SECTOR_W-1:0]          peak_sector,
    output logic                         mean_valid,
    output logic [ANGLE_W-1:0]           mean_angle,
    output logic [SAMPLE_W-1:0]          mean_samples,
    output logic [CNT_W-1:0]             pulse_total,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]             cfg_data
);

    // configuration
    logic [ADC_WIDTH-1:0]   tol_reg, tol_next;
    logic [SCALE_W-1:0]     avg_scale_reg, avg_scale_next;
    logic [SCALE_W-1:0]     peak_scale_reg, peak_scale_next;

    // window state
    logic [CNT_W-1:0]       window_reg, window_next;
    logic [CNT_W-1:0]       gust_reg, gust_next;
    logic [CNT_W-1:0]       peak_reg, peak_next;
    logic [SECTOR_W-1:0]    peak_dir_reg, peak_dir_next;
    logic [SUM_W-1:0]       sum_cos_reg, sum_cos_next;
    logic [SUM_W-1:0]       sum_sin_reg, sum_sin_next;
    logic [SAMPLE_W-1:0]    count_reg, count_next;

    // sequencer
    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [SECTOR_W-1:0]    idx_reg, idx_next;
    logic [ADC_WIDTH-1:0]   adc_reg, adc_next;
    logic                   hit_reg, hit_next;
    logic [SECTOR_W-1:0]    sector_reg, sector_next;

    // report capture
    logic [SPEED_W-1:0]     rpt_avg_reg, rpt_avg_next;
    logic [SPEED_W-1:0]     rpt_peak_reg, rpt_peak_next;
    logic [SECTOR_W-1:0]    rpt_dir_reg, rpt_dir_next;
    logic [SAMPLE_W-1:0]    rpt_count_reg, rpt_count_next;
    logic [CNT_W-1:0]       rpt_pulses_reg, rpt_pulses_next;
    logic [ANGLE_W-1:0]     rpt_ang_reg, rpt_ang_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   dir_valid_reg, dir_valid_next;
    logic [SECTOR_W-1:0]    dir_sector_reg, dir_sector_next;
    logic                   report_valid_reg, report_valid_next;
    logic [SPEED_W-1:0]     avg_speed_reg, avg_speed_next;
    logic [SPEED_W-1:0]     peak_speed_reg, peak_speed_next;
    logic [SECTOR_W-1:0]    peak_sector_reg, peak_sector_next;
    logic                   mean_valid_reg, mean_valid_next;
    logic [ANGLE_W-1:0]     mean_angle_reg, mean_angle_next;
    logic [SAMPLE_W-1:0]    mean_samples_reg, mean_samples_next;
    logic [CNT_W-1:0]       pulse_total_reg, pulse_total_next;

    logic                   in_accept;
    logic                   out_free;
    logic [ADC_WIDTH-1:0]   ref_adc;
    logic [ADC_WIDTH-1:0]   diff;
    logic                   found;
    cordic_req_t            cordic_req;
    cordic_rsp_t            cordic_rsp;

    wsdm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Distance of the held sample from the current table entry
    always_comb
    begin
        ref_adc = vane_adc(idx_reg);
        diff    = (adc_reg >= ref_adc) ? (adc_reg - ref_adc) : (ref_adc - adc_reg);
        found   = (diff <= tol_reg);
    end

    // Sequencer, state update and result load
    always_comb
    begin
        tol_next          = tol_reg;
        avg_scale_next    = avg_scale_reg;
        peak_scale_next   = peak_scale_reg;
        window_next       = window_reg;
        gust_next         = gust_reg;
        peak_next         = peak_reg;
        peak_dir_next     = peak_dir_reg;
        sum_cos_next      = sum_cos_reg;
        sum_sin_next      = sum_sin_reg;
        count_next        = count_reg;
        state_next        = state_reg;
        mode_next         = mode_reg;
        idx_next          = idx_reg;
        adc_next          = adc_reg;
        hit_next          = hit_reg;
        sector_next       = sector_reg;
        rpt_avg_next      = rpt_avg_reg;
        rpt_peak_next     = rpt_peak_reg;
        rpt_dir_next      = rpt_dir_reg;
        rpt_count_next    = rpt_count_reg;
        rpt_pulses_next   = rpt_pulses_reg;
        rpt_ang_next      = rpt_ang_reg;
        out_valid_next    = out_valid_reg && out_stall;
        dir_valid_next    = dir_valid_reg;
        dir_sector_next   = dir_sector_reg;
        report_valid_next = report_valid_reg;
        avg_speed_next    = avg_speed_reg;
        peak_speed_next   = peak_speed_reg;
        peak_sector_next  = peak_sector_reg;
        mean_valid_next   = mean_valid_reg;
        mean_angle_next   = mean_angle_reg;
        mean_samples_next = mean_samples_reg;
        pulse_total_next  = pulse_total_reg;

        cordic_req.start   = 1'b0;
        cordic_req.sum_cos = sum_cos_reg;
        cordic_req.sum_sin = sum_sin_reg;

        // take configuration writes
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOLERANCE:  tol_next        = cfg_data[ADC_WIDTH-1:0];
                CFG_AVG_SCALE:  avg_scale_next  = cfg_data[SCALE_W-1:0];
                CFG_PEAK_SCALE: peak_scale_next = cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept) begin
                    mode_next   = mode_t'(mode);
                    adc_next    = adc_sample[ADC_WIDTH-1:0];
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    sector_next = '0;
                    case (mode_t'(mode))
                        MODE_PULSE:
                        begin
                            // count the pulse, holding at full scale
                            if (window_reg != CNT_MAX) begin
                                window_next = window_reg + 1'b1;
                            end
                            if (gust_reg != CNT_MAX) begin
                                gust_next = gust_reg + 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        MODE_SAMPLE:
                        begin
                            state_next = ST_MATCH;
                        end
                        MODE_REPORT:
                        begin
                            // capture the window, start the angle, clear the window
                            rpt_avg_next     = SPEED_W'(window_reg) * SPEED_W'(avg_scale_reg);
                            rpt_peak_next    = SPEED_W'(peak_reg) * SPEED_W'(peak_scale_reg);
                            rpt_dir_next     = peak_dir_reg;
                            rpt_count_next   = count_reg;
                            rpt_pulses_next  = window_reg;
                            cordic_req.start = 1'b1;
                            window_next      = '0;
                            peak_next        = '0;
                            sum_cos_next     = '0;
                            sum_sin_next     = '0;
                            count_next       = '0;
                            state_next       = ST_MEAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MATCH:
            begin
                // test one calibration entry a cycle; first match wins
                if (found || idx_reg == SECTOR_W'(SECTORS - 1)) begin
                    hit_next    = found;
                    sector_next = found ? idx_reg : '0;
                    if (found && count_reg < MAX_SAMPLES) begin
                        sum_cos_next = sum_cos_reg + SUM_W'(cos_q14(idx_reg));
                        sum_sin_next = sum_sin_reg + SUM_W'(sin_q14(idx_reg));
                        count_next   = count_reg + 1'b1;
                    end
                    if (gust_reg > peak_reg) begin
                        peak_next = gust_reg;
                        if (found) begin
                            peak_dir_next = idx_reg;
                        end
                    end
                    gust_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MEAN:
            begin
                // wait for the angle unit
                if (cordic_rsp.done) begin
                    rpt_ang_next = cordic_rsp.angle;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the result word once the output register is free
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    dir_valid_next    = 1'b0;
                    dir_sector_next   = '0;
                    report_valid_next = 1'b0;
                    avg_speed_next    = '0;
                    peak_speed_next   = '0;
                    peak_sector_next  = '0;
                    mean_valid_next   = 1'b0;
                    mean_angle_next   = '0;
                    mean_samples_next = '0;
                    pulse_total_next  = '0;
                    case (mode_reg)
                        MODE_SAMPLE:
                        begin
                            dir_valid_next  = hit_reg;
                            dir_sector_next = sector_reg;
                        end
                        MODE_REPORT:
                        begin
                            report_valid_next = 1'b1;
                            avg_speed_next    = rpt_avg_reg;
                            peak_speed_next   = rpt_peak_reg;
                            peak_sector_next  = rpt_dir_reg;
                            pulse_total_next  = rpt_pulses_reg;
                            if (rpt_count_reg != '0) begin
                                mean_valid_next   = 1'b1;
                                mean_angle_next   = rpt_ang_reg;
                                mean_samples_next = rpt_count_reg;
                            end
                        end
                        default: ;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tol_reg        <= 12'd62;
            avg_scale_reg  <= 8'd24;
            peak_scale_reg <= 8'd80;
            window_reg     <= '0;
            gust_reg       <= '0;
            peak_reg       <= '0;
            peak_dir_reg   <= '0;
            sum_cos_reg    <= '0;
            sum_sin_reg    <= '0;
            count_reg      <= '0;
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
        end else begin
            tol_reg        <= tol_next;
            avg_scale_reg  <= avg_scale_next;
            peak_scale_reg <= peak_scale_next;
            window_reg     <= window_next;
            gust_reg       <= gust_next;
            peak_reg       <= peak_next;
            peak_dir_reg   <= peak_dir_next;
            sum_cos_reg    <= sum_cos_next;
            sum_sin_reg    <= sum_sin_next;
            count_reg      <= count_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        idx_reg          <= idx_next;
        adc_reg          <= adc_next;
        hit_reg          <= hit_next;
        sector_reg       <= sector_next;
        rpt_avg_reg      <= rpt_avg_next;
        rpt_peak_reg     <= rpt_peak_next;
        rpt_dir_reg      <= rpt_dir_next;
        rpt_count_reg    <= rpt_count_next;
        rpt_pulses_reg   <= rpt_pulses_next;
        rpt_ang_reg      <= rpt_ang_next;
        dir_valid_reg    <= dir_valid_next;
        dir_sector_reg   <= dir_sector_next;
        report_valid_reg <= report_valid_next;
        avg_speed_reg    <= avg_speed_next;
        peak_speed_reg   <= peak_speed_next;
        peak_sector_reg  <= peak_sector_next;
        mean_valid_reg   <= mean_valid_next;
        mean_angle_reg   <= mean_angle_next;
        mean_samples_reg <= mean_samples_next;
        pulse_total_reg  <= pulse_total_next;
    end

    assign out_valid    = out_valid_reg;
    assign dir_valid    = dir_valid_reg;
    assign dir_sector   = dir_sector_reg;
    assign report_valid = report_valid_reg;
    assign avg_speed    = avg_speed_reg;
    assign peak_speed   = peak_speed_reg;
    assign peak_sector  = peak_sector_reg;
    assign mean_valid   = mean_valid_reg;
    assign mean_angle   = mean_angle_reg;
    assign mean_samples = mean_samples_reg;
    assign pulse_total  = pulse_total_reg;

endmodule

`default_nettype wire

// File: sv/wsdm_cordic.sv
// Iterative CORDIC vectoring unit giving the angle of the summed wind vector.
`timescale 1ns / 1ps
`default_nettype none

module wsdm_cordic
    import wsdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cordic_req_t req,
    output cordic_rsp_t      rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [ANGLE_W-1:0]         ang_reg, ang_next;

    logic signed [CORDIC_W-1:0] x_init;
    logic signed [CORDIC_W-1:0] y_init;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic                       y_pos;

    // Scale the sums up and run one rotation step per cycle while busy, shifting x and y by the step number
    always_comb
    begin
        x_init    = CORDIC_W'($signed(req.sum_cos)) <<< CORDIC_SHIFT;
        y_init    = CORDIC_W'($signed(req.sum_sin)) <<< CORDIC_SHIFT;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        y_pos     = !y_reg[CORDIC_W-1] && (y_reg != '0);

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;

        if (req.start) begin
            step_next = '0;
            if (x_init == '0 && y_init == '0) begin
                // cancelling vectors: angle is zero at once
                ang_next  = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (x_init[CORDIC_W-1]) begin
                // turn into the right half plane
                x_next    = -x_init;
                y_next    = -y_init;
                ang_next  = HALF_TURN;
                busy_next = 1'b1;
            end else begin
                x_next    = x_init;
                y_next    = y_init;
                ang_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (y_pos) begin
                x_next   = x_reg + dx;
                y_next   = y_reg - dy;
                ang_next = ang_reg + atan_units(step_reg);
            end else begin
                x_next   = x_reg - dx;
                y_next   = y_reg + dy;
                ang_next = ang_reg - atan_units(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = ang_reg;

endmodule

`default_nettype wire

// File: test/wind_speed_direction_monitor_checker.sv
// Scoreboard for the wind monitor: follows both channels, predicts each result word and compares.
`timescale 1ns / 1ps

module wind_speed_direction_monitor_checker
    import wsdm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic [1:0]              mode,
    input  wire logic [ADC_WIDTH-1:0]    adc_sample,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic                    dir_valid,
    input  wire logic [SECTOR_W-1:0]     dir_sector,
    input  wire logic                    report_valid,
    input  wire logic [SPEED_W-1:0]      avg_speed,
    input  wire logic [SPEED_W-1:0]      peak_speed,
    input  wire logic [SECTOR_W-1:0]     peak_sector,
    input  wire logic                    mean_valid,
    input  wire logic [ANGLE_W-1:0]      mean_angle,
    input  wire logic [SAMPLE_W-1:0]     mean_samples,
    input  wire logic [CNT_W-1:0]        pulse_total,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]             cfg_data,
    output int                           fail_count,
    output int                           words_due
);

    typedef struct packed {
        logic                 dir_valid;
        logic [SECTOR_W-1:0]  dir_sector;
        logic                 report_valid;
        logic [SPEED_W-1:0]   avg_speed;
        logic [SPEED_W-1:0]   peak_speed;
        logic [SECTOR_W-1:0]  peak_sector;
        logic                 mean_valid;
        logic [ANGLE_W-1:0]   mean_angle;
        logic [SAMPLE_W-1:0]  mean_samples;
        logic [CNT_W-1:0]     pulse_total;
    } wind_word_t;

    // Vane calibration counts, sector trig terms in Q1.14, arctangent steps
    localparam int VANE_COUNTS [16] = '{
        510, 1707, 1491, 3467, 3376, 3572, 2789, 3149,
        2237, 2454, 929, 1022, 153, 410, 276, 724
    };
    localparam int SECTOR_COS [16] = '{
        16384, 15137, 11585, 6270, 0, -6270, -11585, -15137,
        -16384, -15137, -11585, -6270, 0, 6270, 11585, 15137
    };
    localparam int SECTOR_SIN [16] = '{
        0, 6270, 11585, 15137, 16384, 15137, 11585, 6270,
        0, -6270, -11585, -15137, -16384, -15137, -11585, -6270
    };
    localparam int ATAN_STEP [16] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    // Predicted monitor state and register copies
    int                  window_count;
    int                  gust_count;
    int                  peak_count;
    logic [SECTOR_W-1:0] peak_heading;
    int                  east_sum;
    int                  north_sum;
    int                  vector_count;
    logic [11:0]         tolerance;
    logic [7:0]          avg_scale;
    logic [7:0]          peak_scale;

    wind_word_t wind_words_due [$];
    wind_word_t due_word;
    wind_word_t seen_word;
    bit         word_bad;

    // Vectoring CORDIC over the scaled sums; angle wraps at 65536
    function automatic logic [ANGLE_W-1:0] vector_mean_angle(input int sx, input int sy);
        longint x;
        longint y;
        longint dx;
        longint dy;
        int     ang;
        int     i;
        x = longint'(sx) * 256;
        y = longint'(sy) * 256;
        ang = 0;
        if (x == 0 && y == 0)
            return '0;
        // turn the left half plane over by half a circle first
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32768;
        end
        for (i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                ang += ATAN_STEP[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                ang -= ATAN_STEP[i];
            end
        end
        return ang[15:0];
    endfunction

    // Advance the predicted state by one event word and form its result word
    task automatic compute_wind_word(input logic [1:0] kind, input logic [11:0] adc,
                                     output wind_word_t w);
        int                  i;
        int                  diff;
        bit                  hit;
        logic [SECTOR_W-1:0] sect;
        w = '0;
        hit = 1'b0;
        sect = '0;
        case (kind)
            MODE_PULSE:
            begin
                if (window_count < 65535)
                    window_count++;
                if (gust_count < 65535)
                    gust_count++;
            end
            MODE_SAMPLE:
            begin
                // first entry in table order within tolerance wins
                for (i = 0; i < 16; i++)
                begin
                    diff = int'(adc) - VANE_COUNTS[i];
                    if (diff < 0)
                        diff = -diff;
                    if (!hit && diff <= int'(tolerance))
                    begin
                        hit = 1'b1;
                        sect = i[3:0];
                    end
                end
                if (hit && vector_count < 255)
                begin
                    east_sum += SECTOR_COS[sect];
                    north_sum += SECTOR_SIN[sect];
                    vector_count++;
                end
                if (gust_count > peak_count)
                begin
                    peak_count = gust_count;
                    if (hit)
                        peak_heading = sect;
                end
                gust_count = 0;
                w.dir_valid = hit;
                w.dir_sector = sect;
            end
            MODE_REPORT:
            begin
                w.report_valid = 1'b1;
                w.avg_speed = SPEED_W'(window_count * int'(avg_scale));
                w.peak_speed = SPEED_W'(peak_count * int'(peak_scale));
                w.peak_sector = peak_heading;
                if (vector_count != 0)
                begin
                    w.mean_valid = 1'b1;
                    w.mean_angle = vector_mean_angle(east_sum, north_sum);
                    w.mean_samples = SAMPLE_W'(vector_count);
                end
                w.pulse_total = CNT_W'(window_count);
                // clear the window; gust count and peak heading carry over
                window_count = 0;
                peak_count = 0;
                east_sum = 0;
                north_sum = 0;
                vector_count = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic bit field_bad(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count = 0;
            gust_count = 0;
            peak_count = 0;
            peak_heading = '0;
            east_sum = 0;
            north_sum = 0;
            vector_count = 0;
            tolerance = 12'd62;
            avg_scale = 8'd24;
            peak_scale = 8'd80;
            wind_words_due.delete();
            words_due = 0;
            fail_count = 0;
        end
        else
        begin
            // compare a delivered result word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen_word = '{dir_valid, dir_sector, report_valid, avg_speed, peak_speed,
                              peak_sector, mean_valid, mean_angle, mean_samples, pulse_total};
                if (wind_words_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing actual %h",
                             $time, seen_word);
                    fail_count++;
                end
                else
                begin
                    due_word = wind_words_due.pop_front();
                    word_bad = 1'b0;
                    word_bad |= field_bad("dir_valid", due_word.dir_valid, seen_word.dir_valid);
                    word_bad |= field_bad("dir_sector", due_word.dir_sector,
                                          seen_word.dir_sector);
                    word_bad |= field_bad("report_valid", due_word.report_valid,
                                          seen_word.report_valid);
                    word_bad |= field_bad("avg_speed", due_word.avg_speed, seen_word.avg_speed);
                    word_bad |= field_bad("peak_speed", due_word.peak_speed,
                                          seen_word.peak_speed);
                    word_bad |= field_bad("peak_sector", due_word.peak_sector,
                                          seen_word.peak_sector);
                    word_bad |= field_bad("mean_valid", due_word.mean_valid,
                                          seen_word.mean_valid);
                    word_bad |= field_bad("mean_angle", due_word.mean_angle,
                                          seen_word.mean_angle);
                    word_bad |= field_bad("mean_samples", due_word.mean_samples,
                                          seen_word.mean_samples);
                    word_bad |= field_bad("pulse_total", due_word.pulse_total,
                                          seen_word.pulse_total);
                    if (word_bad)
                        fail_count++;
                end
            end

            // follow register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TOLERANCE:  tolerance = cfg_data[11:0];
                    CFG_AVG_SCALE:  avg_scale = cfg_data[7:0];
                    CFG_PEAK_SCALE: peak_scale = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            // predict the word for each accepted event
            if (in_valid && !in_stall)
            begin
                compute_wind_word(mode, adc_sample, due_word);
                wind_words_due.push_back(due_word);
            end
            words_due = wind_words_due.size();
        end
    end

endmodule

// File: test/wind_speed_direction_monitor_test.sv
// Testbench top for the wind monitor: clock, reset, event and register stimulus, verdict.
`timescale 1ns / 1ps

module wind_speed_direction_monitor_test
    import wsdm_pkg::*;
();

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              mode = MODE_NONE;
    logic [ADC_WIDTH-1:0]    adc_sample = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    dir_valid;
    logic [SECTOR_W-1:0]     dir_sector;
    logic                    report_valid;
    logic [SPEED_W-1:0]      avg_speed;
    logic [SPEED_W-1:0]      peak_speed;
    logic [SECTOR_W-1:0]     peak_sector;
    logic                    mean_valid;
    logic [ANGLE_W-1:0]      mean_angle;
    logic [SAMPLE_W-1:0]     mean_samples;
    logic [CNT_W-1:0]        pulse_total;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_TOLERANCE;
    logic [31:0]             cfg_data = '0;

    int fail_count;
    int words_due;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cur_tolerance = 62;

    wind_speed_direction_monitor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dir_valid    (dir_valid),
        .dir_sector   (dir_sector),
        .report_valid (report_valid),
        .avg_speed    (avg_speed),
        .peak_speed   (peak_speed),
        .peak_sector  (peak_sector),
        .mean_valid   (mean_valid),
        .mean_angle   (mean_angle),
        .mean_samples (mean_samples),
        .pulse_total  (pulse_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    wind_speed_direction_monitor_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dir_valid    (dir_valid),
        .dir_sector   (dir_sector),
        .report_valid (report_valid),
        .avg_speed    (avg_speed),
        .peak_speed   (peak_speed),
        .peak_sector  (peak_sector),
        .mean_valid   (mean_valid),
        .mean_angle   (mean_angle),
        .mean_samples (mean_samples),
        .pulse_total  (pulse_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one event word, idling first at random; return at the falling edge after accept
    task automatic send_event(input logic [1:0] kind, input logic [11:0] adc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= kind;
        adc_sample <= adc;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Hold the input until every predicted word has come out, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load all three registers; unused upper data bits carry noise
    task automatic set_config(input int tol, input int avg, input int peak);
        write_reg(CFG_TOLERANCE, ($urandom & 32'hFFFF_F000) | tol);
        write_reg(CFG_AVG_SCALE, ($urandom & 32'hFFFF_FF00) | avg);
        write_reg(CFG_PEAK_SCALE, ($urandom & 32'hFFFF_FF00) | peak);
        cur_tolerance = tol;
    endtask

    // Vane reading: mostly near a calibration entry, sometimes anywhere
    function automatic logic [11:0] vane_reading();
        int base;
        int span;
        int off;
        int v;
        if ($urandom_range(9) < 7)
        begin
            base = int'(vane_adc(SECTOR_W'($urandom_range(15))));
            span = (cur_tolerance > 290) ? 300 : cur_tolerance + 8;
            off = int'($urandom_range(2 * span)) - span;
            v = base + off;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            return v[11:0];
        end
        return 12'($urandom_range(4095));
    endfunction

    // Random weather: pulse bursts closed by a sample tick, reports now and then, some noise
    task automatic run_weather(input int target);
        int done_items;
        int burst;
        int n;
        int pick;
        done_items = 0;
        while (done_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                send_event(MODE_NONE, 12'($urandom_range(4095)));
            else if (pick < 12)
            begin
                send_event(2'($urandom_range(2)), 12'($urandom_range(4095)));
                done_items++;
            end
            else
            begin
                burst = $urandom_range(12);
                for (n = 0; n < burst; n++)
                    send_event(MODE_PULSE, 12'($urandom_range(4095)));
                send_event(MODE_SAMPLE, vane_reading());
                done_items += burst + 1;
                if ($urandom_range(5) == 0)
                begin
                    send_event(MODE_REPORT, 12'($urandom_range(4095)));
                    done_items++;
                end
            end
        end
        send_event(MODE_REPORT, 12'($urandom_range(4095)));
    endtask

    initial
    begin
        int n;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings, no idling
        send_event(MODE_REPORT, 12'd0);         // empty window
        send_event(MODE_NONE, 12'hFFF);         // unused kind
        repeat (3) send_event(MODE_PULSE, 12'hFFF);
        send_event(MODE_SAMPLE, 12'd510);       // first peak, north
        repeat (5) send_event(MODE_PULSE, 12'd0);
        send_event(MODE_SAMPLE, 12'd2237);      // higher peak, south
        repeat (2) send_event(MODE_PULSE, 12'd0);
        send_event(MODE_SAMPLE, 12'hFFF);       // no match, lower gust
        repeat (7) send_event(MODE_PULSE, 12'd0);
        send_event(MODE_SAMPLE, 12'd0);         // higher gust without a match keeps heading
        send_event(MODE_SAMPLE, 12'd975);       // two entries in range, earlier wins
        send_event(MODE_SAMPLE, 12'd214);
        send_event(MODE_REPORT, 12'd0);
        send_event(MODE_SAMPLE, 12'd510);       // opposite vectors cancel
        send_event(MODE_SAMPLE, 12'd2237);
        send_event(MODE_REPORT, 12'd0);
        send_event(MODE_SAMPLE, 12'd3376);
        send_event(MODE_REPORT, 12'hFFF);
        run_weather(130);
        drain_results();

        // Exact matching, top scales: a gust at top scale and the sample limit
        set_config(0, 255, 255);
        write_reg(CFG_UNUSED, $urandom);
        for (n = 0; n < 20; n++)
            send_event(MODE_PULSE, 12'($urandom_range(4095)));
        send_event(MODE_SAMPLE, 12'd3467);
        repeat (4) send_event(MODE_PULSE, 12'd0);
        send_event(MODE_REPORT, 12'd0);
        for (n = 0; n < 260; n++)
            send_event(MODE_SAMPLE, vane_adc(n[3:0]));
        send_event(MODE_REPORT, 12'd0);
        send_idle_pct = 67;
        run_weather(130);
        drain_results();

        // Everything matches north, zero scales, receiver stalling
        send_idle_pct = 0;
        stall_pct = 67;
        set_config(4095, 0, 0);
        run_weather(130);
        drain_results();

        // Mid-range settings with both sides idling
        send_idle_pct = 29;
        stall_pct = 29;
        set_config($urandom_range(10, 150), $urandom_range(1, 254), $urandom_range(1, 254));
        run_weather(130);
        drain_results();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
